@@ hdl/pfra_pkg.sv @@
`default_nettype none

package pfra_pkg;

   localparam int NUM_PAGES_DEF  = 4096;
   localparam int PAGE_SHIFT_DEF = 21;

   localparam int FUNC_W   = 3;
   localparam int ADDR_W   = 33;
   localparam int SIZE_W   = 34;
   localparam int STATUS_W = 2;
   localparam int REF_W    = 8;

   localparam logic [REF_W-1:0] REF_MAX  = 8'hFF;
   localparam logic [REF_W-1:0] REF_FREE = 8'h00;
   localparam logic [REF_W-1:0] REF_ONE  = 8'h01;

   typedef enum logic [FUNC_W-1:0] {
      FN_USABLE       = 3'd0,
      FN_RESERVED     = 3'd1,
      FN_INC          = 3'd2,
      FN_DEC          = 3'd3,
      FN_ALLOC_ONE    = 3'd4,
      FN_ALLOC_CONTIG = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_OK      = 2'd0,
      RS_NOSPACE = 2'd1,
      RS_TOOBIG  = 2'd2,
      RS_OUTSIDE = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       start_walk;
      logic       walk;
      logic       start_scan;
      logic       scan;
      logic       fill;
      logic       pend_load;
      logic       pend_hit;
      status_type pend_status;
      logic       out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      func_type func;
      logic     outside;
      logic     toobig;
      logic     zero_len;
      logic     walk_done;
      logic     hit;
      logic     miss;
      logic     fill_done;
      logic     clear_done;
   } sts_type;

endpackage

`default_nettype wire

@@ hdl/pfra_ctrl.sv @@
`default_nettype none

module pfra_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pfra_pkg::cmd_type      cmd,
   input  wire pfra_pkg::sts_type sts
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_CHECK = 7'b0000100,
      ST_WALK  = 7'b0001000,
      ST_SCAN  = 7'b0010000,
      ST_FILL  = 7'b0100000,
      ST_POST  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            case (sts.func)
               pfra_pkg::FN_USABLE, pfra_pkg::FN_RESERVED,
               pfra_pkg::FN_INC, pfra_pkg::FN_DEC: begin
                  if (sts.outside) begin
                     cmd.pend_load   = 1'b1;
                     cmd.pend_status = pfra_pkg::RS_OUTSIDE;
                     state_in        = ST_POST;
                  end else begin
                     cmd.start_walk = 1'b1;
                     state_in       = ST_WALK;
                  end
               end
               pfra_pkg::FN_ALLOC_ONE: begin
                  cmd.start_scan = 1'b1;
                  state_in       = ST_SCAN;
               end
               pfra_pkg::FN_ALLOC_CONTIG: begin
                  if (sts.toobig) begin
                     cmd.pend_load   = 1'b1;
                     cmd.pend_status = pfra_pkg::RS_TOOBIG;
                     state_in        = ST_POST;
                  end else if (sts.zero_len) begin
                     cmd.pend_load   = 1'b1;
                     cmd.pend_status = pfra_pkg::RS_OK;
                     state_in        = ST_POST;
                  end else begin
                     cmd.start_scan = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: begin
                  cmd.pend_load   = 1'b1;
                  cmd.pend_status = pfra_pkg::RS_OK;
                  state_in        = ST_POST;
               end
            endcase
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_done) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = pfra_pkg::RS_OK;
               state_in        = ST_POST;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_hit    = 1'b1;
               cmd.pend_status = pfra_pkg::RS_OK;
               state_in = (sts.func == pfra_pkg::FN_ALLOC_CONTIG) ? ST_FILL : ST_POST;
            end else if (sts.miss) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = pfra_pkg::RS_NOSPACE;
               state_in        = ST_POST;
            end
         end
         ST_FILL: begin
            if (sts.fill_done) begin
               state_in = ST_POST;
            end else begin
               cmd.fill = 1'b1;
            end
         end
         ST_POST: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_POST))
      else $error("result raised outside post state");
`endif

endmodule

`default_nettype wire

@@ hdl/pfra_dp.sv @@
`default_nettype none

module pfra_dp #(
   parameter int NUM_PAGES  = pfra_pkg::NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = pfra_pkg::PAGE_SHIFT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [pfra_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [pfra_pkg::ADDR_W-1:0]     req_base_addr,
   input  wire logic [pfra_pkg::SIZE_W-1:0]     req_size_bytes,
   output logic      [pfra_pkg::ADDR_W-1:0]     rsp_page_addr,
   output logic      [pfra_pkg::STATUS_W-1:0]   rsp_status,
   input  wire pfra_pkg::cmd_type               cmd,
   output pfra_pkg::sts_type                    sts
);

   localparam int AW      = pfra_pkg::ADDR_W;
   localparam int RW      = pfra_pkg::REF_W;
   localparam int IDX_W   = $clog2(NUM_PAGES);
   localparam int CNT_W   = $clog2(NUM_PAGES + 1);
   localparam int FIRST_W = pfra_pkg::ADDR_W - PAGE_SHIFT;
   localparam int CW      = pfra_pkg::SIZE_W + 1 - PAGE_SHIFT;
   localparam int SUM_W   = ((CW + 1) > CNT_W) ? (CW + 1) : (CNT_W + 1);
   localparam int XW      = CNT_W + 1;

   logic [RW-1:0] mem [NUM_PAGES];

   pfra_pkg::func_type             func_ff;
   logic [FIRST_W-1:0]             first_ff;
   logic [pfra_pkg::SIZE_W-1:0]    size_ff;

   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] run_ff, run_in, run_nx;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [RW-1:0]    rdata_ff;

   logic [AW-1:0]         pend_addr_ff;
   pfra_pkg::status_type  pend_status_ff;
   logic [AW-1:0]         out_addr_ff;
   pfra_pkg::status_type  out_status_ff;

   logic [CW-1:0]    pg_dn, pg_cnt;
   logic             round_up;
   logic [SUM_W-1:0] end_sum;

   logic             hit_one, hit_contig;
   logic [IDX_W-1:0] start_idx, hit_idx;
   logic [RW-1:0]    walk_val;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [RW-1:0]    wr_data;

   // page count and range check on the captured request
   always_comb begin
      round_up = func_ff inside {pfra_pkg::FN_RESERVED, pfra_pkg::FN_ALLOC_CONTIG};
      pg_dn    = CW'(size_ff >> PAGE_SHIFT);
      pg_cnt   = pg_dn + CW'(round_up && (size_ff[PAGE_SHIFT-1:0] != '0));
      end_sum  = SUM_W'(first_ff) + SUM_W'(pg_cnt);
   end

   always_comb begin
      run_nx     = (rdata_ff == pfra_pkg::REF_FREE) ? (run_ff + 1'b1) : '0;
      hit_one    = rd_valid_ff && (func_ff == pfra_pkg::FN_ALLOC_ONE) &&
                   (rdata_ff == pfra_pkg::REF_FREE);
      hit_contig = rd_valid_ff && (func_ff == pfra_pkg::FN_ALLOC_CONTIG) &&
                   (run_nx == cnt_ff);
      start_idx  = IDX_W'(CNT_W'(rd_idx_ff) + 1'b1 - cnt_ff);
      hit_idx    = (func_ff == pfra_pkg::FN_ALLOC_ONE) ? rd_idx_ff : start_idx;
   end

   always_comb begin
      case (func_ff)
         pfra_pkg::FN_USABLE:   walk_val = pfra_pkg::REF_FREE;
         pfra_pkg::FN_RESERVED: walk_val = pfra_pkg::REF_MAX;
         pfra_pkg::FN_INC:
            walk_val = (rdata_ff == pfra_pkg::REF_MAX) ? rdata_ff : (rdata_ff + 1'b1);
         pfra_pkg::FN_DEC:
            walk_val = (rdata_ff == pfra_pkg::REF_FREE) ? rdata_ff : (rdata_ff - 1'b1);
         default:               walk_val = rdata_ff;
      endcase
   end

   always_comb begin
      sts.func       = func_ff;
      sts.outside    = end_sum > SUM_W'(NUM_PAGES);
      sts.toobig     = SUM_W'(pg_cnt) > SUM_W'(NUM_PAGES);
      sts.zero_len   = (pg_cnt == '0);
      sts.walk_done  = (left_ff == '0) && !rd_valid_ff;
      sts.hit        = hit_one || hit_contig;
      sts.miss       = rd_valid_ff && (rd_idx_ff == IDX_W'(NUM_PAGES - 1)) &&
                       !(hit_one || hit_contig);
      sts.fill_done  = (left_ff == '0);
      sts.clear_done = (ptr_ff == CNT_W'(NUM_PAGES - 1));
   end

   // pointer, counters and read pipeline
   always_comb begin
      ptr_in      = ptr_ff;
      left_in     = left_ff;
      cnt_in      = cnt_ff;
      run_in      = run_ff;
      rd_valid_in = 1'b0;
      if (cmd.clear) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (cmd.start_walk) begin
         ptr_in  = CNT_W'(first_ff);
         left_in = CNT_W'(pg_cnt);
      end
      if (cmd.walk && (left_ff != '0)) begin
         ptr_in      = ptr_ff + 1'b1;
         left_in     = left_ff - 1'b1;
         rd_valid_in = 1'b1;
      end
      if (cmd.start_scan) begin
         ptr_in = '0;
         run_in = '0;
         cnt_in = CNT_W'(pg_cnt);
      end
      if (cmd.scan) begin
         if (ptr_ff != CNT_W'(NUM_PAGES)) begin
            ptr_in      = ptr_ff + 1'b1;
            rd_valid_in = 1'b1;
         end
         if (rd_valid_ff) begin
            run_in = run_nx;
         end
         if (hit_contig) begin
            ptr_in  = CNT_W'(start_idx);
            left_in = cnt_ff;
         end
      end
      if (cmd.fill) begin
         ptr_in  = ptr_ff + 1'b1;
         left_in = left_ff - 1'b1;
      end
   end

   // single write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff[IDX_W-1:0];
      wr_data = pfra_pkg::REF_MAX;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.fill) begin
         wr_en   = 1'b1;
         wr_data = pfra_pkg::REF_ONE;
      end else if (cmd.walk && rd_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff;
         wr_data = walk_val;
      end else if (cmd.scan && hit_one) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff;
         wr_data = pfra_pkg::REF_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff  <= mem[ptr_ff[IDX_W-1:0]];
      rd_idx_ff <= ptr_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         ptr_ff      <= ptr_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      cnt_ff  <= cnt_in;
      run_ff  <= run_in;
      if (cmd.capture) begin
         func_ff  <= pfra_pkg::func_type'(req_func);
         first_ff <= FIRST_W'(req_base_addr >> PAGE_SHIFT);
         size_ff  <= req_size_bytes;
      end
      if (cmd.pend_load) begin
         pend_status_ff <= cmd.pend_status;
         pend_addr_ff   <= cmd.pend_hit ? (AW'(hit_idx) << PAGE_SHIFT) : '0;
      end
      if (cmd.out_load) begin
         out_addr_ff   <= pend_addr_ff;
         out_status_ff <= pend_status_ff;
      end
   end

   assign rsp_page_addr = out_addr_ff;
   assign rsp_status    = out_status_ff;

`ifndef SYNTHESIS
   a_fill_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> (left_ff != '0))
      else $error("fill step with no pages left");

   a_run_in_map: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && hit_contig) |-> ((XW'(rd_idx_ff) + 1'b1) >= XW'(cnt_ff)))
      else $error("free run starts below page zero");
`endif

endmodule

`default_nettype wire

@@ hdl/page_frame_refcount_allocator.sv @@
`default_nettype none

// channel   ports                                       direction
// req       req_valid req_stall req_func req_base_addr  in
//           req_size_bytes
// rsp       rsp_valid rsp_stall rsp_page_addr rsp_status out
//
// one request at a time; the count map is a single memory, one read and one write a cycle
// mark/inc/dec: a walk over the pages of the range; alloc one: a linear scan of the map
// alloc contiguous: a scan, then a fill of the run
// after reset a clearing pass sets every count to 255, req_stall high
// a finished result sits in the output register; the next request is taken meanwhile

module page_frame_refcount_allocator #(
   parameter int NUM_PAGES  = pfra_pkg::NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = pfra_pkg::PAGE_SHIFT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [pfra_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [pfra_pkg::ADDR_W-1:0]     req_base_addr,
   input  wire logic [pfra_pkg::SIZE_W-1:0]     req_size_bytes,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [pfra_pkg::ADDR_W-1:0]     rsp_page_addr,
   output logic      [pfra_pkg::STATUS_W-1:0]   rsp_status
);

   pfra_pkg::cmd_type cmd;
   pfra_pkg::sts_type sts;

   pfra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   pfra_dp #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_base_addr  (req_base_addr),
      .req_size_bytes (req_size_bytes),
      .rsp_page_addr  (rsp_page_addr),
      .rsp_status     (rsp_status),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

`default_nettype wire

@@ dv/frame_refcount_checker.sv @@
module frame_refcount_checker
   import pfra_pkg::*;
#(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ADDR_W-1:0]   req_base_addr,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [ADDR_W-1:0]   rsp_page_addr,
   input  logic [STATUS_W-1:0] rsp_status,
   output int                  fail_count,
   output int                  owed,
   output int                  replies_seen,
   output int                  refusals
);

   typedef struct packed {
      logic [ADDR_W-1:0] page_addr;
      status_type        status;
   } frame_reply_t;

   logic [REF_W-1:0] frame_refs [NUM_PAGES];
   frame_reply_t     owed_replies [$];
   frame_reply_t     want;
   frame_reply_t     fresh;
   int               idx;

   // applies one request to the local count map and returns the reply it owes
   task automatic predict_frame_op(
      input  logic [FUNC_W-1:0] f,
      input  logic [ADDR_W-1:0] b,
      input  logic [SIZE_W-1:0] s,
      output frame_reply_t      r
   );
      int first;
      int span_down;
      int span_up;
      int span;
      int run;
      int i;
      int k;
      first     = int'(b >> PAGE_SHIFT);
      span_down = int'(s >> PAGE_SHIFT);
      span_up   = span_down + (((s & ((SIZE_W'(1) << PAGE_SHIFT) - 1)) != 0) ? 1 : 0);
      r.page_addr = '0;
      r.status    = RS_OK;
      case (f)
         FN_USABLE, FN_RESERVED, FN_INC, FN_DEC: begin
            span = (f == FN_RESERVED) ? span_up : span_down;
            if (first + span > NUM_PAGES) begin
               r.status = RS_OUTSIDE;
            end else begin
               for (i = first; i < first + span; i++) begin
                  if (f == FN_USABLE) begin
                     frame_refs[i] = REF_FREE;
                  end else if (f == FN_RESERVED) begin
                     frame_refs[i] = REF_MAX;
                  end else if (f == FN_INC) begin
                     if (frame_refs[i] != REF_MAX) frame_refs[i] = frame_refs[i] + 1'b1;
                  end else if (frame_refs[i] != REF_FREE) begin
                     frame_refs[i] = frame_refs[i] - 1'b1;
                  end
               end
            end
         end
         FN_ALLOC_ONE: begin
            r.status = RS_NOSPACE;
            for (i = 0; i < NUM_PAGES; i++) begin
               if (frame_refs[i] == REF_FREE) begin
                  frame_refs[i] = REF_ONE;
                  r.page_addr   = ADDR_W'(i) << PAGE_SHIFT;
                  r.status      = RS_OK;
                  break;
               end
            end
         end
         FN_ALLOC_CONTIG: begin
            run = 0;
            if (span_up > NUM_PAGES) begin
               r.status = RS_TOOBIG;
            end else if (span_up != 0) begin
               r.status = RS_NOSPACE;
               for (i = 0; i < NUM_PAGES; i++) begin
                  run = (frame_refs[i] == REF_FREE) ? run + 1 : 0;
                  if (run == span_up) begin
                     for (k = i + 1 - span_up; k <= i; k++) frame_refs[k] = REF_ONE;
                     r.page_addr = ADDR_W'(i + 1 - span_up) << PAGE_SHIFT;
                     r.status    = RS_OK;
                     break;
                  end
               end
            end
         end
         default: begin
            // undefined codes leave the map alone
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (idx = 0; idx < NUM_PAGES; idx++) frame_refs[idx] = REF_MAX;
         owed_replies.delete();
         fail_count   = 0;
         owed         = 0;
         replies_seen = 0;
         refusals     = 0;
      end else begin
         // the reply leaving now belongs to an older request, so check it first
         if (rsp_valid && !rsp_stall) begin
            replies_seen++;
            if (owed_replies.size() == 0) begin
               $error("reply with nothing outstanding: page_addr %h status %0d",
                      rsp_page_addr, rsp_status);
               fail_count++;
            end else begin
               want = owed_replies.pop_front();
               if (want.status != RS_OK) refusals++;
               if (want.page_addr !== rsp_page_addr) begin
                  $error("page_addr: expected %h, actual %h", want.page_addr, rsp_page_addr);
                  fail_count++;
               end
               if (want.status !== rsp_status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_frame_op(req_func, req_base_addr, req_size_bytes, fresh);
            owed_replies.push_back(fresh);
         end
         owed = owed_replies.size();
      end
   end

endmodule

@@ dv/page_frame_refcount_allocator_test.sv @@
module page_frame_refcount_allocator_test;
   import pfra_pkg::*;

   localparam int NUM_PAGES      = NUM_PAGES_DEF;
   localparam int PAGE_SHIFT     = PAGE_SHIFT_DEF;
   localparam int PHASE_ITEMS    = 37;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 16;

   localparam logic [FUNC_W-1:0] FN_UNDEF_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FN_UNDEF_HI = 3'd7;

   localparam logic [SIZE_W-1:0] PAGE_BYTES = SIZE_W'(1) << PAGE_SHIFT;
   localparam logic [SIZE_W-1:0] PAGE_MASK  = PAGE_BYTES - 1;
   localparam logic [SIZE_W-1:0] MAP_BYTES  = SIZE_W'(NUM_PAGES) << PAGE_SHIFT;
   localparam logic [ADDR_W-1:0] TOP_ADDR   = '1;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func;
   logic [ADDR_W-1:0]   req_base_addr;
   logic [SIZE_W-1:0]   req_size_bytes;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ADDR_W-1:0]   rsp_page_addr;
   logic [STATUS_W-1:0] rsp_status;

   int fail_count;
   int owed;
   int replies_seen;
   int refusals;
   int sender_idle_pct   = 23;
   int receiver_idle_pct = 77;

   page_frame_refcount_allocator #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_base_addr  (req_base_addr),
      .req_size_bytes (req_size_bytes),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_page_addr  (rsp_page_addr),
      .rsp_status     (rsp_status)
   );

   frame_refcount_checker #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_base_addr  (req_base_addr),
      .req_size_bytes (req_size_bytes),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_page_addr  (rsp_page_addr),
      .rsp_status     (rsp_status),
      .fail_count     (fail_count),
      .owed           (owed),
      .replies_seen   (replies_seen),
      .refusals       (refusals)
   );

   function automatic logic [ADDR_W-1:0] page_base(input int page);
      return ADDR_W'(page) << PAGE_SHIFT;
   endfunction

   function automatic logic [SIZE_W-1:0] pages_of(input int n);
      return SIZE_W'(n) << PAGE_SHIFT;
   endfunction

   // holds the request until a transfer happens; valid stays high into the next one
   task automatic send_frame_op(
      input logic [FUNC_W-1:0] f,
      input logic [ADDR_W-1:0] b,
      input logic [SIZE_W-1:0] s
   );
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_base_addr  <= b;
      req_size_bytes <= s;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("FAIL page_frame_refcount_allocator");
      $finish;
   end

   initial begin
      int                phase;
      int                n;
      int                pick;
      int                pages;
      int                page;
      logic [FUNC_W-1:0] f;
      logic [ADDR_W-1:0] b;
      logic [SIZE_W-1:0] s;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = '0;
      req_base_addr  = '0;
      req_size_bytes = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the whole map starts reserved
      send_frame_op(FN_ALLOC_ONE, '0, '0);
      send_frame_op(FN_ALLOC_CONTIG, '0, PAGE_BYTES);
      send_frame_op(FN_USABLE, '0, '0);
      send_frame_op(FN_USABLE, '0, pages_of(64) | PAGE_MASK);
      send_frame_op(FN_USABLE, TOP_ADDR, PAGE_BYTES);
      send_frame_op(FN_USABLE, page_base(NUM_PAGES - 1), pages_of(2));
      send_frame_op(FN_RESERVED, page_base(10) | ADDR_W'(1), SIZE_W'(1));
      send_frame_op(FN_RESERVED, page_base(20), '0);
      send_frame_op(FN_ALLOC_ONE, '0, '0);
      send_frame_op(FN_ALLOC_CONTIG, '0, '0);
      send_frame_op(FN_ALLOC_CONTIG, '0, MAP_BYTES + 1);
      send_frame_op(FN_ALLOC_CONTIG, '0, '1);
      send_frame_op(FN_ALLOC_CONTIG, '0, MAP_BYTES);
      send_frame_op(FN_ALLOC_CONTIG, '0, pages_of(3));
      send_frame_op(FN_INC, '0, pages_of(4));
      send_frame_op(FN_INC, page_base(10), PAGE_BYTES);
      send_frame_op(FN_DEC, '0, pages_of(8));
      send_frame_op(FN_DEC, '0, pages_of(4) | PAGE_MASK);
      send_frame_op(FN_ALLOC_CONTIG, '0, pages_of(9) + 1);
      send_frame_op(FN_UNDEF_LO, TOP_ADDR, '1);
      send_frame_op(FN_UNDEF_HI, '0, '0);
      // a run that ends exactly on the last page
      send_frame_op(FN_USABLE, page_base(NUM_PAGES - 64), pages_of(64));
      send_frame_op(FN_ALLOC_CONTIG, '0, pages_of(64));
      send_frame_op(FN_RESERVED, '0, MAP_BYTES + 1);
      send_frame_op(FN_INC, TOP_ADDR, '1);
      send_frame_op(FN_USABLE, '0, MAP_BYTES);
      send_frame_op(FN_ALLOC_CONTIG, '0, MAP_BYTES);
      send_frame_op(FN_DEC, '0, MAP_BYTES);

      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = (phase == 0) ? 23 : (phase == 1) ? 77 : 0;
         receiver_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 23 : 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick  = $urandom_range(99);
            // mostly short ranges low in the map, where allocations land
            pages = ($urandom_range(9) == 0) ? $urandom_range(NUM_PAGES) : $urandom_range(8);
            page  = ($urandom_range(3) == 0) ? $urandom_range(NUM_PAGES - 1)
                                             : $urandom_range(127);
            b = page_base(page) | (ADDR_W'($urandom) & ADDR_W'(PAGE_MASK));
            s = pages_of(pages) | ($urandom_range(1) ? (SIZE_W'($urandom) & PAGE_MASK)
                                                     : SIZE_W'(0));
            if (pick < 20)      f = FN_USABLE;
            else if (pick < 28) f = FN_RESERVED;
            else if (pick < 40) f = FN_INC;
            else if (pick < 55) f = FN_DEC;
            else if (pick < 73) f = FN_ALLOC_ONE;
            else if (pick < 90) f = FN_ALLOC_CONTIG;
            else begin
               f = FUNC_W'($urandom_range(7));
               b = ADDR_W'({$urandom, $urandom});
               s = SIZE_W'({$urandom, $urandom});
            end
            send_frame_op(f, b, s);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d replies, %0d of them refusals (no space, too large, outside map)",
               replies_seen, refusals);
      $display("stimulus: directed corner requests, then %0d random ones over three stall mixes",
               3 * PHASE_ITEMS);
      if (fail_count == 0) begin
         $display("PASS page_frame_refcount_allocator");
      end else begin
         $display("FAIL page_frame_refcount_allocator");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/pfra_pkg.sv
hdl/pfra_ctrl.sv
hdl/pfra_dp.sv
hdl/page_frame_refcount_allocator.sv
dv/frame_refcount_checker.sv
dv/page_frame_refcount_allocator_test.sv
